// ===== rtl/n2a_pkg.sv =====
// ----------------------------------------------------------------------------
// n2a_pkg
// Shared types, codes and tables of the number to ASCII formatter: operation
// codes, the microcode control word and program, and the character tables.
// ----------------------------------------------------------------------------
package n2a_pkg;

    localparam int OP_W    = 3;
    localparam int WORD_W  = 32;
    localparam int CHAR_W  = 7;
    localparam int MASK_W  = 8;
    localparam int STEP_W  = 4;
    localparam int PTR_W   = 5;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = 4 * DIGITS;

    localparam int TRACK_BITS_DEFAULT = 5;
    localparam logic [MASK_W-1:0] MASK_RESET = 8'd31;

    // operation codes
    localparam logic [OP_W-1:0] OP_UDEC  = 3'd0;
    localparam logic [OP_W-1:0] OP_SDEC  = 3'd1;
    localparam logic [OP_W-1:0] OP_HEX   = 3'd2;
    localparam logic [OP_W-1:0] OP_MILLI = 3'd3;
    localparam logic [OP_W-1:0] OP_TRACK = 3'd4;

    // program addresses
    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SIGN   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MINUS  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_CONV   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SKIP   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DIG    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DOT    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_POINT  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_TEXT_T = 4'd8;
    localparam logic [STEP_W-1:0] STEP_HEXHI  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_HEXLO  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_TEXT_B = 4'd11;
    localparam logic [STEP_W-1:0] STEP_BITS   = 4'd12;
    localparam logic [STEP_W-1:0] STEP_TEXT_E = 4'd13;

    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_CONST,
        SRC_DIGIT,
        SRC_HEX_HI,
        SRC_HEX_LO,
        SRC_TEXT,
        SRC_BIT
    } src_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_DABBLE,
        ACT_SKIP,
        ACT_SHIFT_DIG,
        ACT_TEXT_INC,
        ACT_BIT_DEC
    } act_t;

    typedef enum logic [1:0] {
        LAST_NONE,
        LAST_DIG,
        LAST_NOT_TRACK,
        LAST_TEXT_END
    } last_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_DISPATCH,
        COND_NOT_NEG,
        COND_CONV_MORE,
        COND_SKIP,
        COND_DIG_MORE,
        COND_DIG_DONE,
        COND_TEXT_MORE,
        COND_NOT_TRACK,
        COND_BITS_MORE
    } cond_t;

    typedef struct packed {
        src_t              src;
        logic [CHAR_W-1:0] ch;
        act_t              act;
        last_t             last;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              stop;
    } ctrl_t;

    // microcode program: taken jump goes to target, else pc+1, or idle on stop
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] pc);
        ctrl_t w;
        w.src    = SRC_NONE;
        w.ch     = 7'h00;
        w.act    = ACT_NONE;
        w.last   = LAST_NONE;
        w.cond   = COND_NEVER;
        w.target = STEP_IDLE;
        w.stop   = 1'b0;
        case (pc)
            STEP_IDLE:
            begin
                w.cond = COND_DISPATCH;
            end
            STEP_SIGN:
            begin
                w.cond   = COND_NOT_NEG;
                w.target = STEP_CONV;
            end
            STEP_MINUS:
            begin
                w.src = SRC_CONST;
                w.ch  = 7'("-");
            end
            STEP_CONV:
            begin
                w.act    = ACT_DABBLE;
                w.cond   = COND_CONV_MORE;
                w.target = STEP_CONV;
            end
            STEP_SKIP:
            begin
                w.act    = ACT_SKIP;
                w.cond   = COND_SKIP;
                w.target = STEP_SKIP;
            end
            STEP_DIG:
            begin
                w.src    = SRC_DIGIT;
                w.act    = ACT_SHIFT_DIG;
                w.last   = LAST_DIG;
                w.cond   = COND_DIG_MORE;
                w.target = STEP_DIG;
            end
            STEP_DOT:
            begin
                w.cond   = COND_DIG_DONE;
                w.target = STEP_IDLE;
            end
            STEP_POINT:
            begin
                w.src    = SRC_CONST;
                w.ch     = 7'(".");
                w.cond   = COND_ALWAYS;
                w.target = STEP_DIG;
            end
            STEP_TEXT_T:
            begin
                w.src    = SRC_TEXT;
                w.act    = ACT_TEXT_INC;
                w.cond   = COND_TEXT_MORE;
                w.target = STEP_TEXT_T;
            end
            STEP_HEXHI:
            begin
                w.src = SRC_HEX_HI;
            end
            STEP_HEXLO:
            begin
                w.src    = SRC_HEX_LO;
                w.last   = LAST_NOT_TRACK;
                w.cond   = COND_NOT_TRACK;
                w.target = STEP_IDLE;
            end
            STEP_TEXT_B:
            begin
                w.src    = SRC_TEXT;
                w.act    = ACT_TEXT_INC;
                w.cond   = COND_TEXT_MORE;
                w.target = STEP_TEXT_B;
            end
            STEP_BITS:
            begin
                w.src    = SRC_BIT;
                w.act    = ACT_BIT_DEC;
                w.cond   = COND_BITS_MORE;
                w.target = STEP_BITS;
            end
            STEP_TEXT_E:
            begin
                w.src    = SRC_TEXT;
                w.act    = ACT_TEXT_INC;
                w.last   = LAST_TEXT_END;
                w.cond   = COND_TEXT_MORE;
                w.target = STEP_TEXT_E;
                w.stop   = 1'b1;
            end
            default:
            begin
                w.stop = 1'b1;
            end
        endcase
        return w;
    endfunction

    // program entry for each operation, idle for unused codes
    function automatic logic [STEP_W-1:0] entry_step(input logic [OP_W-1:0] op);
        logic [STEP_W-1:0] s;
        case (op)
            OP_UDEC, OP_SDEC, OP_MILLI: s = STEP_SIGN;
            OP_HEX:                     s = STEP_HEXHI;
            OP_TRACK:                   s = STEP_TEXT_T;
            default:                    s = STEP_IDLE;
        endcase
        return s;
    endfunction

    // frame text: "TRACK mask=0x", " bits=", CR LF
    function automatic logic [CHAR_W-1:0] text_char(input logic [PTR_W-1:0] i);
        logic [CHAR_W-1:0] c;
        case (i)
            5'd0:    c = 7'("T");
            5'd1:    c = 7'("R");
            5'd2:    c = 7'("A");
            5'd3:    c = 7'("C");
            5'd4:    c = 7'("K");
            5'd5:    c = 7'(" ");
            5'd6:    c = 7'("m");
            5'd7:    c = 7'("a");
            5'd8:    c = 7'("s");
            5'd9:    c = 7'("k");
            5'd10:   c = 7'("=");
            5'd11:   c = 7'("0");
            5'd12:   c = 7'("x");
            5'd13:   c = 7'(" ");
            5'd14:   c = 7'("b");
            5'd15:   c = 7'("i");
            5'd16:   c = 7'("t");
            5'd17:   c = 7'("s");
            5'd18:   c = 7'("=");
            5'd19:   c = 7'h0D;
            5'd20:   c = 7'h0A;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // last character of each text segment
    function automatic logic text_end(input logic [PTR_W-1:0] i);
        return (i == 5'd12) || (i == 5'd18) || (i == 5'd20);
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
        logic [CHAR_W-1:0] c;
        if (n < 4'd10)
        begin
            c = 7'("0") + {3'b000, n};
        end
        else
        begin
            c = 7'("A") + {3'b000, n} - 7'd10;
        end
        return c;
    endfunction

endpackage

// ===== rtl/n2a_in_if.sv =====
// ----------------------------------------------------------------------------
// n2a_in_if
// Input channel of the formatter: operation code and value word.
// ----------------------------------------------------------------------------
interface n2a_in_if
    import n2a_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [WORD_W-1:0] value_word;

    modport source (output valid, output operation, output value_word, input ready);
    modport sink   (input valid, input operation, input value_word, output ready);
endinterface

// ===== rtl/n2a_out_if.sv =====
// ----------------------------------------------------------------------------
// n2a_out_if
// Output channel of the formatter: one ASCII character and its last flag.
// ----------------------------------------------------------------------------
interface n2a_out_if
    import n2a_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ascii_char;
    logic              last_char;

    modport source (output valid, output ascii_char, output last_char, input ready);
    modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

// ===== rtl/number_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// Formats a 32-bit word as ASCII text, one character per output item, under
// control of a small microcode program with a step counter and jumps.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    operation[2:0], value_word[31:0]
//  out_ch    out   valid/ready    ascii_char[6:0], last_char
//  cfg       in    cfg_we         cfg_data[7:0] (track bit mask)
//
//  one item at a time; in_ch.ready is high only while the sequencer idles
//  decimal items: an optional '-', the serial binary to bcd loop, zero skip and
//  digits, milli with a '.'; hex: two digits; track: text, hex mask and bits
//  each output character sits in an output register; a stalled output holds
//  the sequencer on its current step when that step emits a character
//  async reset clears the step counter and the output valid, sets the mask (31)
//
module number_to_ascii_formatter
    import n2a_pkg::*;
#(
    parameter int TRACK_BITS = TRACK_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [MASK_W-1:0] cfg_data,
    n2a_in_if.sink            in_ch,
    n2a_out_if.source         out_ch
);

    localparam int NB = (TRACK_BITS > 8) ? 8 : TRACK_BITS;

    logic [STEP_W-1:0] pc_reg, pc_next;
    logic [WORD_W-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [4:0]        conv_cnt_reg, conv_cnt_next;
    logic [3:0]        dig_cnt_reg, dig_cnt_next;
    logic [7:0]        byte_reg, byte_next;
    logic [PTR_W-1:0]  text_ptr_reg, text_ptr_next;
    logic [3:0]        bit_n_reg, bit_n_next;
    logic              neg_reg, neg_next;
    logic              milli_reg, milli_next;
    logic              track_reg, track_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    ctrl_t             cw;
    logic              emits;
    logic              out_free;
    logic              adv;
    logic              taken;
    logic              skip_ok;
    logic              in_fire;
    logic [CHAR_W-1:0] char_sel;
    logic              last_sel;
    logic [3:0]        dig_min;
    logic [2:0]        bit_idx;
    logic [BCD_W-1:0]  bcd_adj;

    assign cw       = ucode(pc_reg);
    assign emits    = (cw.src != SRC_NONE);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign adv      = (pc_reg == STEP_IDLE) ? 1'b1 : (!emits || out_free);

    assign in_ch.ready       = (pc_reg == STEP_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.ascii_char = out_char_reg;
    assign out_ch.last_char  = out_last_reg;

    // milli mode keeps at least four digits: one integer and three fraction
    assign dig_min = milli_reg ? 4'd4 : 4'd1;
    assign skip_ok = (bcd_reg[BCD_W-1 -: 4] == 4'd0) && (dig_cnt_reg > dig_min);
    assign bit_idx = 3'(bit_n_reg - 4'd1);

    // add-3 correction on every bcd digit before the shift
    always_comb
    begin
        logic [3:0] d;
        for (int i = 0; i < DIGITS; i++)
        begin
            d = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    // jump condition
    always_comb
    begin
        case (cw.cond)
            COND_NEVER:     taken = 1'b0;
            COND_ALWAYS:    taken = 1'b1;
            COND_DISPATCH:  taken = 1'b1;
            COND_NOT_NEG:   taken = !neg_reg;
            COND_CONV_MORE: taken = (conv_cnt_reg != 5'd31);
            COND_SKIP:      taken = skip_ok;
            COND_DIG_MORE:  taken = (dig_cnt_reg != 4'd1)
                                    && !(milli_reg && (dig_cnt_reg == 4'd4));
            COND_DIG_DONE:  taken = (dig_cnt_reg == 4'd0);
            COND_TEXT_MORE: taken = !text_end(text_ptr_reg);
            COND_NOT_TRACK: taken = !track_reg;
            COND_BITS_MORE: taken = (bit_n_reg != 4'd1);
            default:        taken = 1'b0;
        endcase
    end

    // character and last flag of the current step
    always_comb
    begin
        case (cw.src)
            SRC_CONST:  char_sel = cw.ch;
            SRC_DIGIT:  char_sel = 7'("0") + {3'b000, bcd_reg[BCD_W-1 -: 4]};
            SRC_HEX_HI: char_sel = hex_char(byte_reg[7:4]);
            SRC_HEX_LO: char_sel = hex_char(byte_reg[3:0]);
            SRC_TEXT:   char_sel = text_char(text_ptr_reg);
            SRC_BIT:    char_sel = 7'("0") + {6'd0, byte_reg[bit_idx]};
            default:    char_sel = 7'h00;
        endcase
        case (cw.last)
            LAST_NONE:      last_sel = 1'b0;
            LAST_DIG:       last_sel = (dig_cnt_reg == 4'd1);
            LAST_NOT_TRACK: last_sel = !track_reg;
            LAST_TEXT_END:  last_sel = text_end(text_ptr_reg);
            default:        last_sel = 1'b0;
        endcase
    end

    // step counter and datapath next values
    always_comb
    begin
        pc_next       = pc_reg;
        mag_next      = mag_reg;
        bcd_next      = bcd_reg;
        conv_cnt_next = conv_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        byte_next     = byte_reg;
        text_ptr_next = text_ptr_reg;
        bit_n_next    = bit_n_reg;
        neg_next      = neg_reg;
        milli_next    = milli_reg;
        track_next    = track_reg;
        mask_next     = cfg_we ? cfg_data : mask_reg;

        if (pc_reg == STEP_IDLE)
        begin
            if (in_fire)
            begin
                pc_next       = entry_step(in_ch.operation);
                neg_next      = (in_ch.operation inside {OP_SDEC, OP_MILLI})
                                && in_ch.value_word[WORD_W-1];
                mag_next      = neg_next ? (WORD_W'(0) - in_ch.value_word)
                                         : in_ch.value_word;
                milli_next    = (in_ch.operation == OP_MILLI);
                track_next    = (in_ch.operation == OP_TRACK);
                byte_next     = track_next ? (in_ch.value_word[7:0] & mask_reg)
                                           : in_ch.value_word[7:0];
                bcd_next      = '0;
                conv_cnt_next = 5'd0;
                dig_cnt_next  = 4'(DIGITS);
                text_ptr_next = '0;
                bit_n_next    = 4'(NB);
            end
        end
        else if (adv)
        begin
            if (taken)
            begin
                pc_next = cw.target;
            end
            else if (cw.stop)
            begin
                pc_next = STEP_IDLE;
            end
            else
            begin
                pc_next = pc_reg + 4'd1;
            end

            case (cw.act)
                ACT_DABBLE:
                begin
                    bcd_next      = {bcd_adj[BCD_W-2:0], mag_reg[WORD_W-1]};
                    mag_next      = {mag_reg[WORD_W-2:0], 1'b0};
                    conv_cnt_next = conv_cnt_reg + 5'd1;
                end
                ACT_SKIP:
                begin
                    if (skip_ok)
                    begin
                        bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                        dig_cnt_next = dig_cnt_reg - 4'd1;
                    end
                end
                ACT_SHIFT_DIG:
                begin
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 4'd1;
                end
                ACT_TEXT_INC:
                begin
                    text_ptr_next = text_ptr_reg + 5'd1;
                end
                ACT_BIT_DEC:
                begin
                    bit_n_next = bit_n_reg - 4'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // output register
    always_comb
    begin
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if ((pc_reg != STEP_IDLE) && emits && out_free)
        begin
            out_char_next  = char_sel;
            out_last_next  = last_sel;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_IDLE;
            out_valid_reg <= 1'b0;
            mask_reg      <= MASK_RESET;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        conv_cnt_reg <= conv_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        byte_reg     <= byte_next;
        text_ptr_reg <= text_ptr_next;
        bit_n_reg    <= bit_n_next;
        neg_reg      <= neg_next;
        milli_reg    <= milli_next;
        track_reg    <= track_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule
